>>> rtl/core/dpd_pkg.sv
`timescale 1ns / 1ps
// Package for the debug packet deframer: character codes, event and phase
// types, the result word struct and the lenient hex digit decode.
// No dependencies.
package dpd_pkg;

    localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_BREAK = 8'h03;
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] HEX_TEN  = 8'd10;

    typedef enum logic [3:0] {
        EV_IGNORED = 4'd0,
        EV_PAYLOAD = 4'd1,
        EV_ACK     = 4'd2,
        EV_NAK     = 4'd3,
        EV_START   = 4'd4,
        EV_DIGIT   = 4'd5,
        EV_GOOD    = 4'd6,
        EV_BAD     = 4'd7,
        EV_BREAK   = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_DIGIT1  = 2'd1,
        PH_DIGIT2  = 2'd2,
        PH_IDLE    = 2'd3
    } t_phase;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [7:0] packet_length;
        logic       overflow;
    } t_result;

    // Lenient hex digit: {below '0', low 8 bits of the digit value}.
    function automatic logic [8:0] f_hex_digit(input logic [7:0] ch);
        logic [8:0] res;
        res = {1'b0, 8'(ch - CH_ZERO)};
        if (ch inside {[CH_LA:CH_LF]}) begin
            res = {1'b0, 8'(ch - CH_LA + HEX_TEN)};
        end else if (ch inside {[CH_UA:CH_UF]}) begin
            res = {1'b0, 8'(ch - CH_UA + HEX_TEN)};
        end else if (ch < CH_ZERO) begin
            res[8] = 1'b1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/dpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: received byte words in,
// event words out. Depends on dpd_pkg.
interface dpd_rx_if import dpd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_ev_if import dpd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_event     event_res;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [7:0] packet_length;
    logic       overflow;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output packet_length, output overflow,
                    input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input packet_length, input overflow,
                    output ready);
endinterface

>>> rtl/core/dpd_in_stage.sv
`timescale 1ns / 1ps
// Input register of the deframer: holds one received byte word until the
// engine takes it. Depends on dpd_pkg and dpd_rx_if.
module dpd_in_stage import dpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dpd_rx_if.sink       i_rx,
    input  logic         i_take,
    output logic         o_valid,
    output logic [7:0]   o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

>>> rtl/core/dpd_engine.sv
`timescale 1ns / 1ps
// Framing engine: packet phase, running sum, position, first checksum digit
// and overflow flag, plus the per-byte decode. Depends on dpd_pkg.
module dpd_engine import dpd_pkg::*; #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_result    o_res
);
    localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(BUFFER_DEPTH);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_first, n_first;
    logic             r_ovf, n_ovf;

    logic [8:0] lo_dig;
    logic [8:0] hi_dig;
    logic       sum_match;

    always_comb begin
        lo_dig    = f_hex_digit(i_byte);
        hi_dig    = f_hex_digit(r_first);
        sum_match = !lo_dig[8] && !hi_dig[8] && (hi_dig[7:4] == 4'd0) &&
                    ((lo_dig[7:0] | {hi_dig[3:0], 4'd0}) == r_sum);
    end

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_pos   = r_pos;
        n_first = r_first;
        n_ovf   = r_ovf;
        o_res   = '0;
        o_res.event_res = EV_IGNORED;

        if (i_byte == CH_ACK) begin
            o_res.event_res = EV_ACK;
        end else if (i_byte == CH_NAK) begin
            o_res.event_res = EV_NAK;
        end else if (i_byte == CH_START) begin
            n_phase = PH_COLLECT;
            n_sum   = '0;
            n_pos   = '0;
            n_first = '0;
            n_ovf   = 1'b0;
            o_res.event_res = EV_START;
        end else begin
            case (r_phase)
                PH_COLLECT: begin
                    if (i_byte == CH_HASH) begin
                        n_phase = PH_DIGIT1;
                    end else if (i_byte == CH_BREAK) begin
                        n_pos = '0;
                        o_res.event_res = EV_BREAK;
                    end else begin
                        o_res.event_res    = EV_PAYLOAD;
                        o_res.payload_byte = i_byte;
                        n_sum = r_sum + i_byte;
                        if (r_pos < POS_MAX) begin
                            o_res.payload_index = 7'(r_pos);
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                PH_DIGIT1: begin
                    n_first = i_byte;
                    n_phase = PH_DIGIT2;
                    o_res.event_res = EV_DIGIT;
                end
                PH_DIGIT2: begin
                    o_res.packet_length = 8'(r_pos);
                    n_phase = PH_IDLE;
                    if (sum_match) begin
                        o_res.event_res = EV_GOOD;
                        n_sum = '0;
                        n_pos = '0;
                    end else begin
                        o_res.event_res = EV_BAD;
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLLECT;
            r_sum   <= '0;
            r_pos   <= '0;
            r_first <= '0;
            r_ovf   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_first <= n_first;
            r_ovf   <= n_ovf;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("position beyond buffer depth");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_byte == CH_START |=>
            r_phase == PH_COLLECT && r_sum == 8'd0 && r_pos == '0 && !r_ovf)
        else $error("start byte did not clear packet state");

    a_good_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.event_res == EV_GOOD |=>
            r_phase == PH_IDLE && r_sum == 8'd0 && r_pos == '0)
        else $error("good packet did not clear sum and position");

    a_bad_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.event_res == EV_BAD |=>
            r_phase == PH_IDLE && $stable(r_sum) && $stable(r_pos))
        else $error("bad packet changed sum or position");
endmodule

>>> rtl/core/dpd_out_stage.sv
`timescale 1ns / 1ps
// Result register of the deframer: holds one event word for the sink.
// Depends on dpd_pkg and dpd_ev_if.
module dpd_out_stage import dpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_result  i_res,
    output logic     o_space,
    dpd_ev_if.source o_ev
);
    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || o_ev.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_res <= i_res;
        end
    end

    assign o_ev.valid         = r_valid;
    assign o_ev.event_res     = r_res.event_res;
    assign o_ev.payload_byte  = r_res.payload_byte;
    assign o_ev.payload_index = r_res.payload_index;
    assign o_ev.packet_length = r_res.packet_length;
    assign o_ev.overflow      = r_res.overflow;
endmodule

>>> rtl/core/debug_packet_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the debug packet deframer: input register, framing engine
// and result register. Depends on dpd_pkg, dpd_if, dpd_in_stage,
// dpd_engine and dpd_out_stage.
//
// Frames $payload#hh packets from a byte stream and gives exactly one event
// word per received byte word. A byte word waits in the input register
// until the result register has space, and is then decoded into the
// result register, which presents its event word to the sink. A new byte
// word is taken every cycle while the sink keeps up, because the packet
// state updates in the same cycle as the decode. Both sides are registered,
// but input ready follows the sink's ready combinationally whenever both
// stage registers are full. Payload beyond BUFFER_DEPTH characters is
// reported with index zero and sets the overflow flag until the next '$'.
module debug_packet_deframer_top import dpd_pkg::*; #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dpd_rx_if.sink   i_rx,
    dpd_ev_if.source o_ev
);
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_space;
    logic       take;
    t_result    res;

    assign take = in_valid && out_space;

    dpd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    dpd_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    dpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (res),
        .o_space (out_space),
        .o_ev    (o_ev)
    );
endmodule

>>> tb/debug_packet_deframer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for debug_packet_deframer_top: feeds received byte words,
// predicts every event word from a local model of the framer state and checks it.
// Depends on dpd_pkg, dpd_if and the deframer RTL.
module debug_packet_deframer_top_tb;
    import dpd_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RANDOM_BYTES = 1525;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    logic i_clk;
    logic i_rst_n;

    dpd_rx_if rx_if ();
    dpd_ev_if ev_if ();

    debug_packet_deframer_top #(.BUFFER_DEPTH(DEPTH)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_ev   (ev_if)
    );

    logic [7:0] pending_bytes[$];
    t_result    expected_events[$];

    // framer state mirror
    t_phase     fr_phase = PH_COLLECT;
    logic [7:0] fr_sum   = '0;
    logic [8:0] fr_pos   = '0;
    logic [7:0] fr_first = '0;
    logic       fr_ovf   = 1'b0;

    int unsigned total_bytes  = 0;
    int unsigned bytes_in     = 0;
    int unsigned events_out   = 0;
    int unsigned errors       = 0;
    int unsigned good_seen    = 0;
    int unsigned bad_seen     = 0;
    int unsigned ovf_seen     = 0;
    int unsigned src_idle_pct = 7;
    int unsigned snk_idle_pct = 55;
    int unsigned hold_point   = 0;
    int unsigned hold_left    = 0;
    int unsigned idle_cycles  = 0;
    bit          hold_done    = 1'b0;

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] digit_value(logic [7:0] c);
        if (c >= CH_LA && c <= CH_LF) return {24'b0, c - CH_LA} + 32'd10;
        if (c >= CH_UA && c <= CH_UF) return {24'b0, c - CH_UA} + 32'd10;
        return {24'b0, c} - {24'b0, CH_ZERO};
    endfunction

    function automatic t_result frame_byte(logic [7:0] ch);
        t_result     r;
        logic [31:0] got;
        r = '0;
        r.event_res = EV_IGNORED;
        if (ch == CH_ACK) begin
            r.event_res = EV_ACK;
        end else if (ch == CH_NAK) begin
            r.event_res = EV_NAK;
        end else if (ch == CH_START) begin
            fr_phase = PH_COLLECT;
            fr_sum   = '0;
            fr_pos   = '0;
            fr_first = '0;
            fr_ovf   = 1'b0;
            r.event_res = EV_START;
        end else begin
            case (fr_phase)
                PH_COLLECT: begin
                    if (ch == CH_HASH) begin
                        fr_phase = PH_DIGIT1;
                    end else if (ch == CH_BREAK) begin
                        fr_pos = '0;
                        r.event_res = EV_BREAK;
                    end else begin
                        r.event_res = EV_PAYLOAD;
                        r.payload_byte = ch;
                        fr_sum = fr_sum + ch;
                        if (fr_pos < DEPTH) begin
                            r.payload_index = fr_pos[6:0];
                            fr_pos = fr_pos + 1'b1;
                        end else begin
                            fr_ovf = 1'b1;
                        end
                    end
                end
                PH_DIGIT1: begin
                    fr_first = ch;
                    fr_phase = PH_DIGIT2;
                    r.event_res = EV_DIGIT;
                end
                PH_DIGIT2: begin
                    got = digit_value(ch) | (digit_value(fr_first) << 4);
                    r.packet_length = fr_pos[7:0];
                    fr_phase = PH_IDLE;
                    if (got == {24'b0, fr_sum}) begin
                        r.event_res = EV_GOOD;
                        fr_sum = '0;
                        fr_pos = '0;
                    end else begin
                        r.event_res = EV_BAD;
                    end
                end
                default: ;
            endcase
        end
        r.overflow = fr_ovf;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? CH_UA : CH_LA) + 8'(n) - HEX_TEN;
    endfunction

    // $payload#hh with random content; mostly correct sums, some broken tails
    task automatic add_packet(bit long_one);
        int unsigned len;
        int unsigned kind;
        logic [7:0]  b;
        logic [7:0]  sum;
        sum = '0;
        len = (long_one || $urandom_range(39) == 0) ? $urandom_range(140, 120)
                                                     : $urandom_range(24);
        pending_bytes.push_back(CH_START);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(29) == 0) begin
                case ($urandom_range(2))
                    0: b = CH_ACK;
                    1: b = CH_NAK;
                    default: b = CH_BREAK;
                endcase
            end else begin
                do b = 8'($urandom_range(255));
                while (b == CH_START || b == CH_HASH || b == CH_ACK || b == CH_NAK ||
                       b == CH_BREAK);
                sum = sum + b;
            end
            pending_bytes.push_back(b);
        end
        kind = $urandom_range(9);
        if (kind != 0) begin
            pending_bytes.push_back(CH_HASH);
            if (kind == 1) sum = sum + 8'($urandom_range(255, 1));
            if (kind == 2) begin
                pending_bytes.push_back(8'($urandom_range(255)));
                pending_bytes.push_back(8'($urandom_range(255)));
            end else begin
                pending_bytes.push_back(hex_char(sum[7:4], 1'($urandom_range(1))));
                pending_bytes.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
            end
        end
        repeat ($urandom_range(2)) pending_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            fr_phase = PH_COLLECT;
            fr_sum   = '0;
            fr_pos   = '0;
            fr_first = '0;
            fr_ovf   = 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                expected_events.push_back(frame_byte(rx_if.rx_byte));
                bytes_in++;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= pending_bytes.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ev_if.ready <= 1'b0;
        end else begin
            if (ev_if.valid && ev_if.ready) begin
                events_out++;
                if (expected_events.size() == 0) begin
                    $error("event word %0d with no byte word pending", ev_if.event_res);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", want.event_res, ev_if.event_res);
                    check_field("payload_byte", want.payload_byte, ev_if.payload_byte);
                    check_field("payload_index", want.payload_index, ev_if.payload_index);
                    check_field("packet_length", want.packet_length, ev_if.packet_length);
                    check_field("overflow", want.overflow, ev_if.overflow);
                end
                if (ev_if.event_res == EV_GOOD) good_seen++;
                if (ev_if.event_res == EV_BAD) bad_seen++;
                if ((ev_if.event_res == EV_GOOD || ev_if.event_res == EV_BAD) && ev_if.overflow)
                    ovf_seen++;
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                ev_if.ready <= 1'b0;
            end else if (!hold_done && bytes_in >= hold_point) begin
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                ev_if.ready <= 1'b0;
            end else begin
                ev_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $error("no progress for %0d cycles, %0d event words outstanding",
                   STALL_LIMIT, expected_events.size());
            $display("debug_packet_deframer_top_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        ev_if.ready   = 1'b0;

        // ack/nak at reset, break as a digit, lenient and mixed-case sums,
        // break and nak inside payload, junk while idle
        pending_bytes = '{CH_ACK, CH_NAK, CH_HASH, CH_BREAK, 8'h00, "x", CH_HASH,
                          CH_START, 8'h00, 8'hFF, CH_BREAK, CH_NAK, 8'h80, CH_HASH,
                          "7", "F",
                          CH_START, 8'hAB, CH_HASH, "a", "b",
                          CH_START, 8'hA0, CH_HASH, ":", "0"};
        add_packet(1'b1);
        while (pending_bytes.size() < RANDOM_BYTES + 26) add_packet(1'b0);
        total_bytes = pending_bytes.size();
        hold_point  = total_bytes * 2 / 3 + 40;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_in < total_bytes / 3) @(posedge i_clk);
        src_idle_pct = 55;
        snk_idle_pct = 7;
        while (bytes_in < total_bytes * 2 / 3) @(posedge i_clk);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (bytes_in < total_bytes || expected_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d byte words through three idle mixes and one long output stall,",
                 bytes_in);
        $display("checked %0d event words: %0d good, %0d bad packets, %0d with overflow.",
                 events_out, good_seen, bad_seen, ovf_seen);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("debug_packet_deframer_top_tb: PASS");
        end else begin
            $display("debug_packet_deframer_top_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dpd_pkg.sv
rtl/core/dpd_if.sv
rtl/core/dpd_in_stage.sv
rtl/core/dpd_engine.sv
rtl/core/dpd_out_stage.sv
rtl/core/debug_packet_deframer_top.sv
tb/debug_packet_deframer_top_tb.sv
